/* rtl/core/dnd_pkg.sv */
// Shared types and constants for the DNS name decompressor.
// No dependencies; the other files that use it refer to this package by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package dnd_pkg;

    // store size default, name limits
    localparam int STORE_BYTES_DEF = 512;
    localparam int NAME_LIMIT      = 255;
    localparam int HOP_LIMIT       = 16;

    // walk position: 14-bit pointer targets plus one label past them
    localparam int PW         = 15;
    localparam int LEN_W      = 8;
    localparam int HOP_W      = 5;
    localparam int NAME_WORDS = (NAME_LIMIT + 4) / 4;
    localparam int NWW        = $clog2(NAME_WORDS);
    localparam int NRES_W     = $clog2(NAME_WORDS + 1);

    // top bits of a length byte
    localparam logic [1:0] KIND_LABEL = 2'b00;
    localparam logic [1:0] KIND_PTR   = 2'b11;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_DECODE = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_DECODE = 2'd2
    } t_cmd_kind;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_LABEL    = 3'd1,
        ST_PAST_END     = 3'd2,
        ST_TOO_LONG     = 3'd3,
        ST_TOO_MANY_HOP = 3'd4
    } t_status;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  data;
        logic [8:0]  offset;
    } t_cmd;

    // chars[7:0] is the first character of the result
    typedef struct packed {
        logic [31:0] chars;
        logic [2:0]  count;
        logic        last;
        t_status     status;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/dns_name_decompressor.sv */
// The idle back end takes one clear or append request per cycle. Decode: a length byte
// passes S_LEN_RD and S_LEN_EVAL, a pointer also S_PTR_EVAL; label characters come one
// per cycle (store read port), then S_FLUSH and, while the output queue has room, one
// result per cycle from the name buffer; an error or empty name gives its single result.
// Reset (synchronous, active low) empties both queues and sets the fill count to zero;
// store and name buffer contents stay undefined and are never read before written.
`timescale 1ns / 1ps
`default_nettype none

module dns_name_decompressor #(
    parameter int STORE_BYTES = dnd_pkg::STORE_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_op,
    input  wire logic [7:0] i_data_byte,
    input  wire logic [8:0] i_start_offset,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_char_a,
    output logic [7:0]      o_char_b,
    output logic [7:0]      o_char_c,
    output logic [7:0]      o_char_d,
    output logic [2:0]      o_char_count,
    output logic            o_last,
    output logic [2:0]      o_status
);

    dnd_pkg::t_cmd    cmd;
    logic             cmd_valid;
    logic             cmd_pop;
    dnd_pkg::t_result result;

    // request classification and command queue
    dnd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_data_byte    (i_data_byte),
        .i_start_offset (i_start_offset),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_pop      (cmd_pop)
    );

    // store, name walk and result stream
    dnd_back #(
        .STORE_BYTES (STORE_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (result)
    );

    // result fields
    assign o_char_a     = result.chars[7:0];
    assign o_char_b     = result.chars[15:8];
    assign o_char_c     = result.chars[23:16];
    assign o_char_d     = result.chars[31:24];
    assign o_char_count = result.count;
    assign o_last       = result.last;
    assign o_status     = result.status;

endmodule

`default_nettype wire

/* rtl/core/dnd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/dnd_front.sv */
// Front end: accepts input requests, classifies the op and queues commands.
// Depends on dnd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dnd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [1:0]    i_op,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic [8:0]    i_start_offset,
    output logic               o_cmd_valid,
    output dnd_pkg::t_cmd      o_cmd,
    input  wire logic          i_cmd_pop
);

    localparam int QD = 2;
    localparam int QA = $clog2(QD);
    localparam int QC = $clog2(QD + 1);

    dnd_pkg::t_cmd r_q [QD];
    logic [QA-1:0] r_wp, r_rp;
    logic [QC-1:0] r_cnt;

    dnd_pkg::t_cmd cmd;
    logic          accept;
    logic          push;
    logic          pop;

    assign o_stall     = (r_cnt == QC'(QD));
    assign accept      = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign pop         = i_cmd_pop && o_cmd_valid;

    // classify the op; the unused op is accepted and dropped
    always_comb begin
        cmd.data   = i_data_byte;
        cmd.offset = i_start_offset;
        cmd.kind   = dnd_pkg::CMD_CLEAR;
        push       = 1'b0;
        case (dnd_pkg::t_op'(i_op))
            dnd_pkg::OP_CLEAR: begin
                cmd.kind = dnd_pkg::CMD_CLEAR;
                push     = accept;
            end
            dnd_pkg::OP_APPEND: begin
                cmd.kind = dnd_pkg::CMD_APPEND;
                push     = accept;
            end
            dnd_pkg::OP_DECODE: begin
                cmd.kind = dnd_pkg::CMD_DECODE;
                push     = accept;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    // command queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    // command queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + QA'(1);
            end
            if (pop) begin
                r_rp <= r_rp + QA'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + QC'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - QC'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/dnd_back.sv */
// Back end: owns the message store, walks names, buffers them and streams results.
// Depends on dnd_pkg and dnd_ram.
`timescale 1ns / 1ps
`default_nettype none

module dnd_back #(
    parameter int STORE_BYTES = dnd_pkg::STORE_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  wire dnd_pkg::t_cmd i_cmd,
    output logic               o_cmd_pop,
    output logic               o_valid,
    input  wire logic          i_stall,
    output dnd_pkg::t_result   o_result
);

    localparam int AW     = $clog2(STORE_BYTES);
    localparam int FW     = $clog2(STORE_BYTES + 1);
    localparam int PW     = dnd_pkg::PW;
    localparam int LW     = dnd_pkg::LEN_W;
    localparam int HW     = dnd_pkg::HOP_W;
    localparam int NWW    = dnd_pkg::NWW;
    localparam int NRW    = dnd_pkg::NRES_W;
    localparam int OQ_D   = 4;
    localparam int OQ_A   = $clog2(OQ_D);
    localparam int OQ_C   = $clog2(OQ_D + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN_RD,
        S_LEN_EVAL,
        S_PTR_EVAL,
        S_CHARS,
        S_FLUSH,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state           r_state, n_state;
    logic [FW-1:0]    r_fill, n_fill;
    logic [PW-1:0]    r_pos, n_pos;
    logic [7:0]       r_budget, n_budget;
    logic [HW-1:0]    r_hops, n_hops;
    logic             r_first, n_first;
    logic [5:0]       r_rem, n_rem;
    logic [5:0]       r_ptr_hi, n_ptr_hi;
    logic [LW-1:0]    r_len, n_len;
    logic [31:0]      r_word, n_word;
    dnd_pkg::t_status r_status, n_status;
    logic [NRW-1:0]   r_rd_word, n_rd_word;
    logic [NRW-1:0]   r_nres, n_nres;
    logic             r_inflight, n_inflight;
    logic             r_inf_last, n_inf_last;
    logic [2:0]       r_inf_cnt, n_inf_cnt;

    // store and name buffer ports
    logic             store_we;
    logic [AW-1:0]    store_raddr;
    logic [7:0]       store_rdata;
    logic             name_we;
    logic [31:0]      name_wdata;
    logic [31:0]      name_rdata;

    // walk helpers
    logic [7:0]       b;
    logic [PW-1:0]    pos1;
    logic [PW-1:0]    pos_end;
    logic [PW-1:0]    fill_ext;
    logic [7:0]       cost;
    logic             push_en;
    logic [7:0]       push_char;
    logic             direct_push;
    logic             oq_room;

    // output queue
    dnd_pkg::t_result r_oq [OQ_D];
    logic [OQ_A-1:0]  r_oq_wp, r_oq_rp;
    logic [OQ_C-1:0]  r_oq_cnt;
    dnd_pkg::t_result oq_wdata;
    logic             oq_push;
    logic             oq_pop;

    dnd_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_cmd.data),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    dnd_ram #(
        .WIDTH (32),
        .DEPTH (dnd_pkg::NAME_WORDS)
    ) u_name_buf (
        .i_clk   (i_clk),
        .i_we    (name_we),
        .i_waddr (r_len[LW-1:2]),
        .i_wdata (name_wdata),
        .i_raddr (r_rd_word[NWW-1:0]),
        .o_rdata (name_rdata)
    );

    assign b        = store_rdata;
    assign pos1     = r_pos + PW'(1);
    assign pos_end  = r_pos + PW'(1) + PW'(b);
    assign fill_ext = PW'(r_fill);
    assign cost     = b + 8'd1;
    assign oq_room  = ((OQ_C + 1)'(r_oq_cnt) + (OQ_C + 1)'(r_inflight))
                      < (OQ_C + 1)'(OQ_D);

    // walk sequencer next state
    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_pos      = r_pos;
        n_budget   = r_budget;
        n_hops     = r_hops;
        n_first    = r_first;
        n_rem      = r_rem;
        n_ptr_hi   = r_ptr_hi;
        n_len      = r_len;
        n_word     = r_word;
        n_status   = r_status;
        n_rd_word  = r_rd_word;
        n_nres     = r_nres;
        n_inflight = 1'b0;
        n_inf_last = r_inf_last;
        n_inf_cnt  = r_inf_cnt;
        o_cmd_pop   = 1'b0;
        store_we    = 1'b0;
        store_raddr = r_pos[AW-1:0];
        push_en     = 1'b0;
        push_char   = 8'h2e;
        name_we     = 1'b0;
        name_wdata  = r_word;
        direct_push = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        dnd_pkg::CMD_CLEAR: begin
                            n_fill = '0;
                        end
                        dnd_pkg::CMD_APPEND: begin
                            if (r_fill < FW'(STORE_BYTES)) begin
                                store_we = 1'b1;
                                n_fill   = r_fill + FW'(1);
                            end
                        end
                        dnd_pkg::CMD_DECODE: begin
                            n_pos    = PW'(i_cmd.offset);
                            n_budget = 8'(dnd_pkg::NAME_LIMIT);
                            n_hops   = '0;
                            n_first  = 1'b1;
                            n_len    = '0;
                            n_state  = S_LEN_RD;
                        end
                        default: ;
                    endcase
                end
            end

            // bounds check and read of the length byte
            S_LEN_RD: begin
                if (r_pos >= fill_ext) begin
                    n_status = dnd_pkg::ST_PAST_END;
                    n_state  = S_FINISH;
                end else begin
                    n_state = S_LEN_EVAL;
                end
            end

            S_LEN_EVAL: begin
                if (b == 8'd0) begin
                    n_status = dnd_pkg::ST_OK;
                    n_state  = (r_len == '0) ? S_FINISH : S_FLUSH;
                end else if (b[7:6] == dnd_pkg::KIND_PTR) begin
                    if (pos1 >= fill_ext) begin
                        n_status = dnd_pkg::ST_PAST_END;
                        n_state  = S_FINISH;
                    end else if (r_hops >= HW'(dnd_pkg::HOP_LIMIT)) begin
                        n_status = dnd_pkg::ST_TOO_MANY_HOP;
                        n_state  = S_FINISH;
                    end else begin
                        n_hops      = r_hops + HW'(1);
                        n_ptr_hi    = b[5:0];
                        store_raddr = pos1[AW-1:0];
                        n_state     = S_PTR_EVAL;
                    end
                end else if (b[7:6] != dnd_pkg::KIND_LABEL) begin
                    n_status = dnd_pkg::ST_BAD_LABEL;
                    n_state  = S_FINISH;
                end else if (pos_end >= fill_ext) begin
                    n_status = dnd_pkg::ST_PAST_END;
                    n_state  = S_FINISH;
                end else if (r_budget < cost) begin
                    n_status = dnd_pkg::ST_TOO_LONG;
                    n_state  = S_FINISH;
                end else begin
                    // label accepted: separator unless it is the first label, then stream its bytes
                    n_budget    = r_budget - cost;
                    push_en     = !r_first;
                    n_first     = 1'b0;
                    n_rem       = b[5:0];
                    n_pos       = pos1;
                    store_raddr = pos1[AW-1:0];
                    n_state     = S_CHARS;
                end
            end

            S_PTR_EVAL: begin
                n_pos   = PW'({r_ptr_hi, store_rdata});
                n_state = S_LEN_RD;
            end

            // one label character per cycle
            S_CHARS: begin
                push_en   = 1'b1;
                push_char = store_rdata;
                n_pos     = pos1;
                if (r_rem > 6'd1) begin
                    store_raddr = pos1[AW-1:0];
                    n_rem       = r_rem - 6'd1;
                end else begin
                    n_state = S_LEN_RD;
                end
            end

            // write the partial last word, set up the readout
            S_FLUSH: begin
                name_we   = (r_len[1:0] != 2'd0);
                n_rd_word = '0;
                n_nres    = NRW'(((LW + 1)'(r_len) + (LW + 1)'(3)) >> 2);
                n_state   = S_DRAIN;
            end

            S_DRAIN: begin
                if (r_rd_word == r_nres) begin
                    n_state = S_IDLE;
                end else if (oq_room) begin
                    n_inflight = 1'b1;
                    n_inf_last = (r_rd_word + NRW'(1) == r_nres);
                    if ((r_rd_word + NRW'(1) == r_nres) && (r_len[1:0] != 2'd0)) begin
                        n_inf_cnt = {1'b0, r_len[1:0]};
                    end else begin
                        n_inf_cnt = 3'd4;
                    end
                    n_rd_word = r_rd_word + NRW'(1);
                end
            end

            // single result for an error or an empty name
            S_FINISH: begin
                if (oq_room && !r_inflight) begin
                    direct_push = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // pack characters into 32-bit words of the name buffer
        if (push_en) begin
            if (r_len[1:0] == 2'd0) begin
                n_word = {24'd0, push_char};
            end else begin
                n_word = r_word | ({24'd0, push_char} << {r_len[1:0], 3'b000});
            end
            n_len = r_len + LW'(1);
            if (r_len[1:0] == 2'd3) begin
                name_we    = 1'b1;
                name_wdata = n_word;
            end
        end
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_inflight <= 1'b0;
            r_pos      <= '0;
            r_budget   <= 8'(dnd_pkg::NAME_LIMIT);
            r_hops     <= '0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_inflight <= n_inflight;
            r_pos      <= n_pos;
            r_budget   <= n_budget;
            r_hops     <= n_hops;
        end
        r_first    <= n_first;
        r_rem      <= n_rem;
        r_ptr_hi   <= n_ptr_hi;
        r_len      <= n_len;
        r_word     <= n_word;
        r_status   <= n_status;
        r_rd_word  <= n_rd_word;
        r_nres     <= n_nres;
        r_inf_last <= n_inf_last;
        r_inf_cnt  <= n_inf_cnt;
    end

    // output queue write side: name words returning, or a single status result
    always_comb begin
        oq_push = r_inflight || direct_push;
        if (r_inflight) begin
            oq_wdata.chars  = name_rdata;
            oq_wdata.count  = r_inf_cnt;
            oq_wdata.last   = r_inf_last;
            oq_wdata.status = dnd_pkg::ST_OK;
        end else begin
            oq_wdata.chars  = '0;
            oq_wdata.count  = '0;
            oq_wdata.last   = 1'b1;
            oq_wdata.status = r_status;
        end
    end

    assign o_valid  = (r_oq_cnt != '0);
    assign o_result = r_oq[r_oq_rp];
    assign oq_pop   = o_valid && !i_stall;

    // output queue storage
    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_oq_wp] <= oq_wdata;
        end
    end

    // output queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (oq_push) begin
                r_oq_wp <= r_oq_wp + OQ_A'(1);
            end
            if (oq_pop) begin
                r_oq_rp <= r_oq_rp + OQ_A'(1);
            end
            if (oq_push && !oq_pop) begin
                r_oq_cnt <= r_oq_cnt + OQ_C'(1);
            end else if (oq_pop && !oq_push) begin
                r_oq_cnt <= r_oq_cnt - OQ_C'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* test/dns_name_decompressor_tb.sv */
// Testbench for dns_name_decompressor: loads dns messages, decodes names from them and
// checks every name word against a behavioral label walker. Depends on dnd_pkg and the rtl.
`timescale 1ns / 1ps

module dns_name_decompressor_tb;

    localparam int         STORE_BYTES    = dnd_pkg::STORE_BYTES_DEF;
    localparam logic [7:0] PTR_TAG        = 8'hC0;
    localparam logic [7:0] DOT_CHAR       = 8'h2E;
    localparam int         REQUEST_TARGET = 330;   // directed, one longest name, then random
    localparam int         HOLD_AFTER     = 40;
    localparam int         HOLD_CYCLES    = 600;
    localparam int         DRAIN_CYCLES   = 200;

    typedef struct packed {
        dnd_pkg::t_op op;
        logic [7:0]   data;
        logic [8:0]   offset;
        logic         drain;   // wait for all name words before sending
    } t_request;

    typedef struct packed {
        logic [3:0][7:0]  chars;
        logic [2:0]       count;
        logic             last;
        dnd_pkg::t_status status;
    } t_name_word;

    typedef enum int {
        SHAPE_PLAIN,
        SHAPE_LOOP,
        SHAPE_LONG,
        SHAPE_BAD,
        SHAPE_WILD,
        SHAPE_MAX
    } t_name_shape;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_valid        = 1'b0;
    logic [1:0] i_op           = 2'd0;
    logic [7:0] i_data_byte    = 8'd0;
    logic [8:0] i_start_offset = 9'd0;
    logic       i_stall        = 1'b0;
    wire        o_stall;
    wire        o_valid;
    wire  [7:0] o_char_a;
    wire  [7:0] o_char_b;
    wire  [7:0] o_char_c;
    wire  [7:0] o_char_d;
    wire  [2:0] o_char_count;
    wire        o_last;
    wire  [2:0] o_status;

    dns_name_decompressor u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_data_byte    (i_data_byte),
        .i_start_offset (i_start_offset),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_char_a       (o_char_a),
        .o_char_b       (o_char_b),
        .o_char_c       (o_char_c),
        .o_char_d       (o_char_d),
        .o_char_count   (o_char_count),
        .o_last         (o_last),
        .o_status       (o_status)
    );

    t_request    request_q [$];
    t_name_word  name_word_q [$];
    logic [7:0]  msg_image [$];
    int unsigned name_starts [$];
    int          items_queued = 0;

    // behavioral copy of the store
    logic [7:0]  store_model [STORE_BYTES];
    int unsigned fill_model = 0;

    int   mismatches     = 0;
    int   results_seen   = 0;
    logic offer_taken    = 1'b0;
    int   burst_left     = 1;
    int   gap_left       = 0;
    int   phase_left     = 0;
    int   stall_pct      = 0;
    int   long_hold_left = 0;
    logic long_hold_done = 1'b0;

    logic [7:0] directed_msg [17];
    logic [8:0] directed_offsets [9];

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    // walk labels and pointers from start, queue the expected name words
    function automatic void decode_name(input logic [8:0] start);
        logic [7:0]       name_text [$];
        logic [7:0]       lead;
        int unsigned      pos, budget, hops, len, nres;
        dnd_pkg::t_status st;
        logic             first, done;
        t_name_word       word;
        pos    = 32'(start);
        budget = dnd_pkg::NAME_LIMIT;
        hops   = 0;
        st     = dnd_pkg::ST_OK;
        first  = 1'b1;
        done   = 1'b0;
        while (!done) begin
            if (pos >= fill_model) begin
                st   = dnd_pkg::ST_PAST_END;
                done = 1'b1;
            end else begin
                lead = store_model[pos];
                if (lead == 8'h00) begin
                    done = 1'b1;
                end else if (lead[7:6] == dnd_pkg::KIND_PTR) begin
                    if (pos + 1 >= fill_model) begin
                        st   = dnd_pkg::ST_PAST_END;
                        done = 1'b1;
                    end else if (hops >= dnd_pkg::HOP_LIMIT) begin
                        st   = dnd_pkg::ST_TOO_MANY_HOP;
                        done = 1'b1;
                    end else begin
                        hops++;
                        pos = 32'({lead[5:0], store_model[pos + 1]});
                    end
                end else if (lead[7:6] != dnd_pkg::KIND_LABEL) begin
                    st   = dnd_pkg::ST_BAD_LABEL;
                    done = 1'b1;
                end else if (pos + 1 + 32'(lead) >= fill_model) begin
                    st   = dnd_pkg::ST_PAST_END;
                    done = 1'b1;
                end else if (budget < 32'(lead) + 1) begin
                    st   = dnd_pkg::ST_TOO_LONG;
                    done = 1'b1;
                end else begin
                    budget -= 32'(lead) + 1;
                    if (!first) name_text.push_back(DOT_CHAR);
                    for (int i = 0; i < int'(lead); i++)
                        name_text.push_back(store_model[pos + 1 + i]);
                    first = 1'b0;
                    pos += 1 + 32'(lead);
                end
            end
        end
        // errors drop the partial name
        len  = (st == dnd_pkg::ST_OK) ? name_text.size() : 0;
        nres = (len + 3) / 4;
        if (nres == 0) nres = 1;
        for (int k = 0; k < nres; k++) begin
            word = '0;
            for (int j = 0; j < 4; j++) begin
                if (k * 4 + j < len) begin
                    word.chars[j] = name_text[k * 4 + j];
                    word.count++;
                end
            end
            word.last   = (k == nres - 1);
            word.status = word.last ? st : dnd_pkg::ST_OK;
            name_word_q.push_back(word);
        end
    endfunction

    function automatic void predict_request(input t_request req);
        case (req.op)
            dnd_pkg::OP_CLEAR: fill_model = 0;
            dnd_pkg::OP_APPEND: begin
                // appends to a full store are dropped
                if (fill_model < STORE_BYTES) begin
                    store_model[fill_model] = req.data;
                    fill_model++;
                end
            end
            dnd_pkg::OP_DECODE: decode_name(req.offset);
            default: ;
        endcase
    endfunction

    task automatic queue_request(input dnd_pkg::t_op op, input logic [7:0] data,
                                 input logic [8:0] offset, input logic drain);
        t_request req;
        req.op     = op;
        req.data   = data;
        req.offset = offset;
        req.drain  = drain;
        request_q.push_back(req);
        items_queued++;
    endtask

    task automatic put_label(input int n);
        logic [7:0] v;
        v = 8'(n);
        msg_image.push_back(v);
        repeat (n) begin
            v = 8'($urandom_range(0, 255));
            msg_image.push_back(v);
        end
    endtask

    task automatic put_pointer(input logic [13:0] target);
        msg_image.push_back(PTR_TAG | {2'b00, target[13:8]});
        msg_image.push_back(target[7:0]);
    endtask

    // append one encoded name of the given shape to the message image
    task automatic put_name(input t_name_shape shape);
        int unsigned here;
        int          n;
        logic [7:0]  kind_byte;
        here = msg_image.size();
        name_starts.push_back(here);
        case (shape)
            SHAPE_PLAIN: begin
                n = $urandom_range(0, 4);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0) name_starts.push_back(msg_image.size());
                    put_label(($urandom_range(0, 7) == 0) ? $urandom_range(9, 63)
                                                           : $urandom_range(1, 8));
                end
                // end on a zero or on a pointer to an earlier name or label start
                if (name_starts.size() > 1 && $urandom_range(0, 1) == 1)
                    put_pointer(14'(name_starts[$urandom_range(0, name_starts.size() - 2)]));
                else
                    msg_image.push_back(8'h00);
            end
            SHAPE_LOOP: begin
                if ($urandom_range(0, 1) == 1) put_label($urandom_range(1, 3));
                put_pointer(14'(here));
            end
            SHAPE_LONG: begin
                put_label(63);
                put_pointer(14'(here));
            end
            SHAPE_BAD: begin
                kind_byte = 8'($urandom_range(8'h40, 8'hBF));
                msg_image.push_back(kind_byte);
            end
            SHAPE_WILD: begin
                repeat ($urandom_range(0, 2)) put_label($urandom_range(1, 8));
                put_pointer(14'($urandom_range(0, 16383)));
            end
            SHAPE_MAX: begin
                // 254 characters, spends the budget exactly
                repeat (3) put_label(63);
                put_label(62);
                msg_image.push_back(8'h00);
            end
            default: ;
        endcase
    endtask

    task automatic send_message(input int n_dec, input int n_extra);
        int unsigned off;
        int          pick;
        queue_request(dnd_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                      9'($urandom_range(0, 511)), 1'($urandom_range(0, 1)));
        foreach (msg_image[i])
            queue_request(dnd_pkg::OP_APPEND, msg_image[i], 9'($urandom_range(0, 511)),
                          1'b0);
        repeat (n_extra)
            queue_request(dnd_pkg::OP_APPEND, 8'($urandom_range(0, 255)),
                          9'($urandom_range(0, 511)), 1'b0);
        repeat (n_dec) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      off = name_starts[$urandom_range(0, name_starts.size() - 1)];
            else if (pick < 85) off = $urandom_range(0, msg_image.size() + 2);
            else                off = $urandom_range(0, 511);
            if ($urandom_range(0, 15) == 0)
                queue_request(dnd_pkg::OP_UNUSED, 8'($urandom_range(0, 255)),
                              9'($urandom_range(0, 511)), 1'b0);
            queue_request(dnd_pkg::OP_DECODE, 8'($urandom_range(0, 255)), off[8:0], 1'b0);
        end
    endtask

    task automatic random_message();
        int target, pick;
        msg_image.delete();
        name_starts.delete();
        target = $urandom_range(8, 60);
        while (msg_image.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 62)      put_name(SHAPE_PLAIN);
            else if (pick < 72) put_name(SHAPE_LOOP);
            else if (pick < 80) put_name(SHAPE_LONG);
            else if (pick < 90) put_name(SHAPE_BAD);
            else                put_name(SHAPE_WILD);
        end
        // cut the tail now and then so the last name runs off the end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) msg_image.delete(msg_image.size() - 1);
        send_message($urandom_range(4, 10), 0);
    endtask

    // one name that uses the whole budget; the decode requests mostly start at it
    task automatic max_name_message();
        msg_image.delete();
        name_starts.delete();
        put_name(SHAPE_MAX);
        send_message(6, 0);
    endtask

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("dns_name_decompressor verification failed");
        $finish;
    end

    // request driver: holds a stalled request, otherwise bursts with gaps
    always @(negedge i_clk) begin : drive_requests
        t_request req;
        logic     offer;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || offer_taken) begin
            offer_taken = 1'b0;
            offer       = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (request_q.size() != 0 &&
                         !(request_q[0].drain && name_word_q.size() != 0)) begin
                req = request_q.pop_front();
                offer = 1'b1;
                i_op           <= req.op;
                i_data_byte    <= req.data;
                i_start_offset <= req.offset;
                burst_left--;
                if (burst_left <= 0) begin
                    if ($urandom_range(0, 3) == 0) begin
                        burst_left = $urandom_range(40, 150);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 10);
                        gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40)
                                                                  : $urandom_range(1, 6);
                    end
                end
            end
            i_valid <= offer;
        end
    end

    // receiver stall: random phases plus one long hold-off
    always @(negedge i_clk) begin : drive_stall
        logic hold;
        if (long_hold_left > 0) begin
            long_hold_left--;
            hold = 1'b1;
        end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            long_hold_left = HOLD_CYCLES - 1;
            hold = 1'b1;
        end else begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(4, 40);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end else begin
                phase_left--;
            end
            hold = ($urandom_range(0, 99) < stall_pct);
        end
        i_stall <= hold;
    end

    // accept requests into the predictor, check name words in order
    always @(posedge i_clk) begin : check_results
        t_request   taken;
        t_name_word want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                taken.op     = dnd_pkg::t_op'(i_op);
                taken.data   = i_data_byte;
                taken.offset = i_start_offset;
                taken.drain  = 1'b0;
                predict_request(taken);
                offer_taken = 1'b1;
            end
            if (o_valid && !i_stall) begin
                results_seen++;
                if (name_word_q.size() == 0) begin
                    report_mismatch($sformatf(
                        "name word with none pending: %h %h %h %h cnt %0d last %0d st %0d",
                        o_char_a, o_char_b, o_char_c, o_char_d, o_char_count, o_last,
                        o_status));
                end else begin
                    want = name_word_q.pop_front();
                    if (o_char_a !== want.chars[0] || o_char_b !== want.chars[1] ||
                        o_char_c !== want.chars[2] || o_char_d !== want.chars[3] ||
                        o_char_count !== want.count || o_last !== want.last ||
                        o_status !== want.status) begin
                        report_mismatch($sformatf({
                            "got %h %h %h %h cnt %0d last %0d st %0d, ",
                            "want %h %h %h %h cnt %0d last %0d st %0d"},
                            o_char_a, o_char_b, o_char_c, o_char_d, o_char_count,
                            o_last, o_status,
                            want.chars[0], want.chars[1], want.chars[2], want.chars[3],
                            want.count, want.last, want.status));
                    end
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        int msg_no;
        // empty name, pointer chains, both bad label kinds, self loop, tail cases
        directed_msg = '{8'h00, 8'h02, 8'h61, 8'hFF, 8'hC0, 8'h00, 8'h40, 8'h80, 8'h01,
                         8'h78, 8'hC0, 8'h01, 8'hC0, 8'h0C, 8'h05, 8'h71, 8'hC3};
        directed_offsets = '{9'd0, 9'd1, 9'd6, 9'd7, 9'd8, 9'd12, 9'd14, 9'd16, 9'd511};

        queue_request(dnd_pkg::OP_DECODE, 8'h00, 9'd0, 1'b0);   // nothing loaded yet
        queue_request(dnd_pkg::OP_UNUSED, 8'hFF, 9'h1FF, 1'b0);
        // sender waits here until the first result has come
        queue_request(dnd_pkg::OP_CLEAR, 8'h00, 9'd0, 1'b1);
        foreach (directed_msg[i])
            queue_request(dnd_pkg::OP_APPEND, directed_msg[i], 9'd0, 1'b0);
        foreach (directed_offsets[i])
            queue_request(dnd_pkg::OP_DECODE, 8'h00, directed_offsets[i], 1'b0);

        msg_no = 0;
        while (items_queued < REQUEST_TARGET) begin
            if (msg_no == 0) max_name_message();
            else             random_message();
            msg_no++;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        while (request_q.size() != 0 || i_valid) @(posedge i_clk);
        while (name_word_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("dns_name_decompressor verification clean");
        end else begin
            $display("dns_name_decompressor verification failed");
        end
        $finish;
    end

endmodule

/* dns_name_decompressor.f */
rtl/core/dnd_pkg.sv
rtl/core/dnd_ram.sv
rtl/core/dnd_front.sv
rtl/core/dnd_back.sv
rtl/core/dns_name_decompressor.sv
test/dns_name_decompressor_tb.sv
